// File: hdl/mhpq_pkg.sv
// Shared definitions for the min-heap priority queue: key width, operation
// and status codes, the command and result word types, default capacity.
// No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                    operation;
    logic signed [KEY_W-1:0] key_in;
  } cmd_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] min_key;
    logic [1:0]              status;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/mhpq_cmd_if.sv
// Command channel of the min-heap priority queue: valid/ready plus the
// operation and key fields. Depends on mhpq_pkg.
`default_nettype none

interface mhpq_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [mhpq_pkg::KEY_W-1:0] key_in;

  modport source (output valid, output operation, output key_in, input ready);
  modport sink   (input valid, input operation, input key_in, output ready);
endinterface

`default_nettype wire

// File: hdl/mhpq_res_if.sv
// Result channel of the min-heap priority queue: valid/ready plus the
// removed key, current minimum, entry count and status. Depends on mhpq_pkg.
`default_nettype none

interface mhpq_res_if #(
  parameter int COUNT_W = $clog2(mhpq_pkg::CAPACITY_DEF + 1)
);
  logic                             valid;
  logic                             ready;
  logic signed [mhpq_pkg::KEY_W-1:0] removed_key;
  logic signed [mhpq_pkg::KEY_W-1:0] min_key;
  logic [COUNT_W-1:0]               entry_count;
  logic [1:0]                       status;

  modport source (output valid, output removed_key, output min_key,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input removed_key, input min_key,
                  input entry_count, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: command and result channels,
// heap RAM, sift sequencer and output register.
// Depends on mhpq_pkg, mhpq_cmd_if, mhpq_res_if, mhpq_ram and mhpq_seq.
//
// Usage: each command word on cmd inserts key_in (operation 0) or removes
// the minimum (operation 1) and yields exactly one result word on res: the
// removed key (0 unless a remove succeeded), the minimum after the operation
// (0 when empty), the entry count and a status: ok, insert refused because
// the heap is full, or remove refused because it is empty. Refused commands
// leave the heap as is. One command is worked on at a time. The sift walk
// moves one tree level per cycle through the heap RAM. Reset empties the
// heap at once by clearing the entry count; the RAM is not cleared since
// entries beyond the count are never read. A stalled receiver holds the
// result in the output register; the next command is still worked on, and
// its result waits until the register is free.
`default_nettype none

module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  mhpq_cmd_if.sink   cmd,
  mhpq_res_if.source res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  mhpq_pkg::cmd_t    cmd_word;
  mhpq_pkg::result_t seq_res;
  logic [CNT_W-1:0]  seq_count;
  logic              seq_valid;
  logic              res_take;
  logic              cmd_ready;

  logic                       we;
  logic [IDX_W-1:0]           waddr, raddr_a, raddr_b;
  logic [mhpq_pkg::KEY_W-1:0] wdata, rdata_a, rdata_b;

  // Output register state.
  logic                       out_valid;
  mhpq_pkg::result_t          out_res;
  logic [CNT_W-1:0]           out_count;

  assign cmd_word.operation = cmd.operation;
  assign cmd_word.key_in    = cmd.key_in;
  assign cmd.ready          = cmd_ready;

  // The sequencer hands over its result when the output register is empty
  // or is being emptied in this cycle.
  assign res_take = seq_valid && (!out_valid || res.ready);

  mhpq_ram #(
    .WIDTH (mhpq_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mhpq_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_word),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b),
    .res_valid (seq_valid),
    .res_take  (res_take),
    .res       (seq_res),
    .res_count (seq_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_res   <= seq_res;
      out_count <= seq_count;
    end
  end

  assign res.valid       = out_valid;
  assign res.removed_key = out_res.removed_key;
  assign res.min_key     = out_res.min_key;
  assign res.status      = out_res.status;
  assign res.entry_count = out_count;

endmodule

`default_nettype wire

// File: hdl/mhpq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: hdl/mhpq_seq.sv
// Sift sequencer of the min-heap: walks the tree one level per cycle over
// the heap RAM, keeping the moving key and a copy of the root in registers.
// Depends on mhpq_pkg.
`default_nettype none

module mhpq_seq #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire mhpq_pkg::cmd_t                cmd,
  output logic                               we,
  output logic [IDX_W-1:0]                   waddr,
  output logic [mhpq_pkg::KEY_W-1:0]         wdata,
  output logic [IDX_W-1:0]                   raddr_a,
  output logic [IDX_W-1:0]                   raddr_b,
  input  wire logic [mhpq_pkg::KEY_W-1:0]    rdata_a,
  input  wire logic [mhpq_pkg::KEY_W-1:0]    rdata_b,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output mhpq_pkg::result_t                  res,
  output logic [CNT_W-1:0]                   res_count
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CMP  = 3'd1;
  localparam logic [2:0] S_UP_ROOT = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_CMP  = 3'd4;
  localparam logic [2:0] S_DN_FIN  = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]                       state, state_next;
  logic [IDX_W-1:0]                 pos, pos_next;
  logic signed [mhpq_pkg::KEY_W-1:0] hold, hold_next;
  logic signed [mhpq_pkg::KEY_W-1:0] root, root_next;
  logic signed [mhpq_pkg::KEY_W-1:0] removed, removed_next;
  logic [CNT_W-1:0]                 count, count_next;
  logic [1:0]                       status, status_next;

  logic [IDX_W:0]                   count_ext;
  logic [IDX_W-1:0]                 ins_pos;
  logic [IDX_W-1:0]                 par;
  logic signed [mhpq_pkg::KEY_W-1:0] left_key, right_key, child_key;
  logic                             take_right;
  logic [IDX_W-1:0]                 best;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] q;
    q = p - 1'b1;
    return q >> 1;
  endfunction

  function automatic logic [IDX_W:0] left_of(input logic [IDX_W-1:0] p);
    return {p, 1'b1};
  endfunction

  assign count_ext  = (IDX_W + 1)'(count);
  assign ins_pos    = IDX_W'(count);
  assign par        = parent_of(pos);
  assign left_key   = $signed(rdata_a);
  assign right_key  = $signed(rdata_b);
  // Right child wins only when it exists and is strictly smaller; ties go left.
  assign take_right = ((left_of(pos) + 1'b1) < count_ext) && (right_key < left_key);
  assign child_key  = take_right ? right_key : left_key;
  assign best       = take_right ? IDX_W'(left_of(pos) + 1'b1) : IDX_W'(left_of(pos));

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    hold_next    = hold;
    root_next    = root;
    removed_next = removed;
    count_next   = count;
    status_next  = status;
    we           = 1'b0;
    waddr        = pos;
    wdata        = hold;
    raddr_a      = '0;
    raddr_b      = '0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          removed_next = '0;
          status_next  = mhpq_pkg::STATUS_OK;
          if (cmd.operation == mhpq_pkg::OP_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              status_next = mhpq_pkg::STATUS_FULL;
              state_next  = S_DONE;
            end else begin
              hold_next  = cmd.key_in;
              count_next = CNT_W'(count + 1'b1);
              pos_next   = ins_pos;
              if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = cmd.key_in;
                root_next  = cmd.key_in;
                state_next = S_DONE;
              end else begin
                raddr_a    = parent_of(ins_pos);
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = mhpq_pkg::STATUS_EMPTY;
              state_next  = S_DONE;
            end else begin
              removed_next = root;
              count_next   = CNT_W'(count - 1'b1);
              pos_next     = '0;
              if (count == CNT_W'(1)) begin
                state_next = S_DONE;
              end else begin
                raddr_a    = IDX_W'(count - 1'b1);
                state_next = S_DN_LAST;
              end
            end
          end
        end
      end

      S_UP_CMP: begin
        if (hold < left_key) begin
          // Parent moves down into the hole; the hole climbs one level.
          we       = 1'b1;
          wdata    = rdata_a;
          pos_next = par;
          if (par == '0) begin
            state_next = S_UP_ROOT;
          end else begin
            raddr_a = parent_of(par);
          end
        end else begin
          we         = 1'b1;
          state_next = S_DONE;
        end
      end

      S_UP_ROOT: begin
        we         = 1'b1;
        root_next  = hold;
        state_next = S_DONE;
      end

      S_DN_LAST: begin
        hold_next = rdata_a;
        if (left_of(pos) < count_ext) begin
          raddr_a    = IDX_W'(left_of(pos));
          raddr_b    = IDX_W'(left_of(pos) + 1'b1);
          state_next = S_DN_CMP;
        end else begin
          we         = 1'b1;
          wdata      = rdata_a;
          root_next  = rdata_a;
          state_next = S_DONE;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (child_key < hold) begin
          // Smaller child moves up into the hole; the hole sinks one level.
          wdata = child_key;
          if (pos == '0) begin
            root_next = child_key;
          end
          pos_next = best;
          if (left_of(best) < count_ext) begin
            raddr_a = IDX_W'(left_of(best));
            raddr_b = IDX_W'(left_of(best) + 1'b1);
          end else begin
            state_next = S_DN_FIN;
          end
        end else begin
          if (pos == '0) begin
            root_next = hold;
          end
          state_next = S_DONE;
        end
      end

      S_DN_FIN: begin
        we         = 1'b1;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    pos     <= pos_next;
    hold    <= hold_next;
    root    <= root_next;
    removed <= removed_next;
    status  <= status_next;
  end

  assign cmd_ready       = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.removed_key = removed;
  assign res.min_key     = (count == '0) ? '0 : root;
  assign res.status      = status;
  assign res_count       = count;

endmodule

`default_nettype wire
